// ===== rtl/spg_pkg.sv =====
// ----------------------------------------------------------------------------
// spg_pkg
// Shared types and constants for the step/direction pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

package spg_pkg;

   // Fixed field layout: four motors, 16-bit signed rates
   localparam int FIELD_MOTORS = 4;
   localparam int RATE_W       = 16;
   localparam int MAG_W        = RATE_W + 1;   // holds 32768
   localparam int IDX_W        = 2;
   localparam int CNT_W        = 19;
   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   // Parameter defaults
   localparam int NUM_MOTORS_DEF       = 4;
   localparam int MAX_RATE_DEF         = 4000;
   localparam int TICKS_PER_SECOND_DEF = 1000000;

   localparam logic [FIELD_MOTORS-1:0] DIR_INVERT_RESET = 4'd10;

   // Controller to datapath commands
   typedef struct packed {
      logic             capture;    // latch request payload
      logic             div_init;   // load divisor for motor idx
      logic             div_step;   // one restoring-division step
      logic             store;      // write half period for motor idx
      logic             tick;       // advance all motors by one tick
      logic             out_load;   // load result register
      logic [IDX_W-1:0] idx;
   } spg_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div_last;               // current step is the final one
   } spg_status_type;

endpackage

`default_nettype wire

// ===== rtl/spg_ctrl.sv =====
// ----------------------------------------------------------------------------
// spg_ctrl
// Sequencer: accepts items, runs the per-motor divisions or the tick update,
// and hands results to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_ctrl
   import spg_pkg::*;
#(
   parameter int NUM_MOTORS = NUM_MOTORS_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic           req_tuser,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output spg_cmd_type         cmd,
   input  wire spg_status_type status
);

   localparam int NUM_ACT = (NUM_MOTORS < FIELD_MOTORS) ? NUM_MOTORS : FIELD_MOTORS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ACT - 1);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DIV_INIT = 3'd1;
   localparam logic [2:0] S_DIV_STEP = 3'd2;
   localparam logic [2:0] S_STORE    = 3'd3;
   localparam logic [2:0] S_TICK     = 3'd4;
   localparam logic [2:0] S_RESP     = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.idx      = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               idx_in      = '0;
               state_in    = req_tuser ? S_TICK : S_DIV_INIT;
            end
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.store = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = S_RESP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_DIV_INIT;
            end
         end
         S_TICK: begin
            cmd.tick = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/spg_datapath.sv =====
// ----------------------------------------------------------------------------
// spg_datapath
// Rate capture, serial half-period divider, per-motor counters and step
// levels, direction polarity register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spg_datapath
   import spg_pkg::*;
#(
   parameter int NUM_MOTORS       = NUM_MOTORS_DEF,
   parameter int MAX_RATE         = MAX_RATE_DEF,
   parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [FIELD_MOTORS*RATE_W-1:0] req_tdata,
   input  wire logic                           csr_valid,
   input  wire logic [FIELD_MOTORS-1:0]        csr_data,
   input  wire spg_cmd_type                    cmd,
   output spg_status_type                      status,
   output logic [2*FIELD_MOTORS-1:0]           rsp_tdata,
   output logic [FIELD_MOTORS-1:0]             active_mask
);

   localparam int NUM_ACT = (NUM_MOTORS < FIELD_MOTORS) ? NUM_MOTORS : FIELD_MOTORS;
   localparam int DIV_W   = $clog2(TICKS_PER_SECOND + 1);
   localparam int DC_W    = $clog2(DIV_W);
   localparam int DSR_W   = MAG_W + 1;
   localparam int REM_W   = DSR_W + 1;
   localparam int QX_W    = (DIV_W > CNT_W) ? DIV_W : CNT_W;
   localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(TICKS_PER_SECOND);
   localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(MAX_RATE);
   localparam logic [DC_W-1:0]  DC_TOP    = DC_W'(DIV_W - 1);

   // Captured rates and divider registers
   logic [FIELD_MOTORS*RATE_W-1:0] rates_ff, rates_in;
   logic [DSR_W-1:0] divisor_ff, divisor_in;
   logic             zero_ff, zero_in;
   logic             neg_ff, neg_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quot_ff, quot_in;
   logic [DC_W-1:0]  dcnt_ff, dcnt_in;

   // Per-motor state
   logic [CNT_W-1:0]        hp_ff [FIELD_MOTORS];
   logic [CNT_W-1:0]        hp_in [FIELD_MOTORS];
   logic [CNT_W-1:0]        el_ff [FIELD_MOTORS];
   logic [CNT_W-1:0]        el_in [FIELD_MOTORS];
   logic [FIELD_MOTORS-1:0] act_ff, act_in;
   logic [FIELD_MOTORS-1:0] step_ff, step_in;
   logic [FIELD_MOTORS-1:0] rev_ff, rev_in;
   logic [FIELD_MOTORS-1:0] dinv_ff, dinv_in;
   logic [2*FIELD_MOTORS-1:0] out_ff, out_in;

   logic [RATE_W-1:0] raw;
   logic [MAG_W-1:0]  mag, mag_sat;
   logic [REM_W-1:0]  rem_sh;
   logic              ge;
   logic [QX_W-1:0]   q_ext;
   logic [CNT_W-1:0]  hp_new;
   logic [CNT_W-1:0]  el_inc;

   assign status.div_last = (dcnt_ff == '0);
   assign rsp_tdata       = out_ff;
   assign active_mask     = FIELD_MOTORS'((1 << NUM_ACT) - 1);

   // Rate magnitude with saturation
   always_comb begin
      raw     = rates_ff[cmd.idx*RATE_W +: RATE_W];
      mag     = raw[RATE_W-1] ? (MAG_W'(1 << RATE_W) - {1'b0, raw}) : {1'b0, raw};
      mag_sat = (mag > MAG_LIMIT) ? MAG_LIMIT : mag;
   end

   // Restoring division step and quotient clamp
   always_comb begin
      rem_sh = {rem_ff[REM_W-2:0], DIVIDEND[dcnt_ff]};
      ge     = (rem_sh >= {1'b0, divisor_ff});
      q_ext  = QX_W'(quot_ff);
      hp_new = (q_ext > QX_W'(COUNT_MAX)) ? COUNT_MAX : q_ext[CNT_W-1:0];
   end

   // Divider next values
   always_comb begin
      rates_in   = cmd.capture ? req_tdata : rates_ff;
      divisor_in = divisor_ff;
      zero_in    = zero_ff;
      neg_in     = neg_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      dcnt_in    = dcnt_ff;
      if (cmd.div_init) begin
         divisor_in = {mag_sat, 1'b0};
         zero_in    = (mag_sat == '0);
         neg_in     = raw[RATE_W-1];
         rem_in     = '0;
         quot_in    = '0;
         dcnt_in    = DC_TOP;
      end else if (cmd.div_step) begin
         rem_in  = ge ? (rem_sh - {1'b0, divisor_ff}) : rem_sh;
         quot_in = {quot_ff[DIV_W-2:0], ge};
         dcnt_in = dcnt_ff - 1'b1;
      end
   end

   // Motor state: rate load and tick update
   always_comb begin
      act_in  = act_ff;
      step_in = step_ff;
      rev_in  = rev_ff;
      el_inc  = '0;
      for (int i = 0; i < FIELD_MOTORS; i++) begin
         hp_in[i] = hp_ff[i];
         el_in[i] = el_ff[i];
      end
      if (cmd.store) begin
         hp_in[cmd.idx]  = zero_ff ? '0 : hp_new;
         act_in[cmd.idx] = !zero_ff;
         rev_in[cmd.idx] = neg_ff;
      end else if (cmd.tick) begin
         for (int i = 0; i < FIELD_MOTORS; i++) begin
            el_inc = (el_ff[i] < COUNT_MAX) ? el_ff[i] + 1'b1 : el_ff[i];
            if (act_ff[i]) begin
               if (el_inc >= hp_ff[i]) begin
                  step_in[i] = !step_ff[i];
                  el_in[i]   = '0;
               end else begin
                  el_in[i] = el_inc;
               end
            end
         end
      end
   end

   // Direction polarity and result
   assign dinv_in = csr_valid ? csr_data : dinv_ff;
   assign out_in  = cmd.out_load ? {rev_ff ^ dinv_ff, step_ff} : out_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= '0;
         step_ff <= '0;
         rev_ff  <= '0;
         dinv_ff <= DIR_INVERT_RESET;
         for (int i = 0; i < FIELD_MOTORS; i++) begin
            hp_ff[i] <= '0;
            el_ff[i] <= '0;
         end
      end else begin
         act_ff  <= act_in;
         step_ff <= step_in;
         rev_ff  <= rev_in;
         dinv_ff <= dinv_in;
         for (int i = 0; i < FIELD_MOTORS; i++) begin
            hp_ff[i] <= hp_in[i];
            el_ff[i] <= el_in[i];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rates_ff   <= rates_in;
      divisor_ff <= divisor_in;
      zero_ff    <= zero_in;
      neg_ff     <= neg_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      dcnt_ff    <= dcnt_in;
      out_ff     <= out_in;
   end

endmodule

`default_nettype wire

// ===== rtl/four_channel_step_pulse_generator_top.sv =====
// ----------------------------------------------------------------------------
// four_channel_step_pulse_generator_top
// Step/direction pulse generator for four stepper motors.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: tuser = 1 is a one-microsecond tick, tuser = 0
//   loads four signed step rates from tdata. Every item returns one rsp_*
//   item with the current step and direction levels.
//   csr_* writes the 4-bit direction invert mask; it is always ready and
//   should be written only while no item is in flight.
// Sequencing:
//   A tick item runs S_TICK, then S_RESP, where its result is loaded once the
//   output register is free. A set item runs one restoring division per
//   configured motor, one quotient bit a cycle: S_DIV_INIT, S_DIV_STEP for each
//   of the clog2(TICKS_PER_SECOND+1) quotient bits and S_STORE, then S_RESP
//   after the last motor. One item is processed at a time; req_tready returns
//   the cycle after the result is loaded into the output register.
// Reset:
//   Counters and step levels clear; captured rates are not reset; the invert mask loads 4'b1010.
// Stall:
//   The result register holds while rsp_tready is low. The next item may still
//   be accepted and processed; its result waits until the register is taken,
//   and no further item is accepted until then.
// ----------------------------------------------------------------------------
`default_nettype none

module four_channel_step_pulse_generator_top
   import spg_pkg::*;
#(
   parameter int NUM_MOTORS       = NUM_MOTORS_DEF,
   parameter int MAX_RATE         = MAX_RATE_DEF,
   parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // tdata: rate_front_left, rate_front_right, rate_rear_left, rate_rear_right
   input  wire logic [FIELD_MOTORS*RATE_W-1:0] req_tdata,
   // tuser: cmd
   input  wire logic                           req_tuser,
   // response channel
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // tdata: step_levels[3:0], dir_levels[7:4]
   output logic [2*FIELD_MOTORS-1:0]           rsp_tdata,
   // direction invert register
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [FIELD_MOTORS-1:0]        csr_data
);

   spg_cmd_type             cmd;
   spg_status_type          status;
   logic [FIELD_MOTORS-1:0] active_mask;

   assign csr_ready = 1'b1;

   spg_ctrl #(
      .NUM_MOTORS (NUM_MOTORS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   spg_datapath #(
      .NUM_MOTORS       (NUM_MOTORS),
      .MAX_RATE         (MAX_RATE),
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_tdata   (rsp_tdata),
      .active_mask (active_mask)
   );

   // One item in flight: an accepted item closes the input the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while an item was in flight");

   // Motors beyond the configured count never step
   a_inactive_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[FIELD_MOTORS-1:0] & ~active_mask) == '0))
      else $error("inactive motor shows a step level");

   // Tick, divider, store and output-load commands never overlap
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.div_init, cmd.div_step, cmd.store, cmd.tick, cmd.out_load}))
      else $error("conflicting datapath commands");

   // A result is loaded only when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire
